/* src/linear_interp_resampler_core_defines.svh */
// Assertion macros for the linear interpolation resampler.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef LINEAR_INTERP_RESAMPLER_CORE_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_CORE_DEFINES_SVH

// Check a property on every rising edge, masked while reset is held low.
`define LIR_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check a property on every rising edge, including reset cycles.
`define LIR_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/lir_pkg.sv */
// Shared types and fixed constants of the linear interpolation resampler.
// No dependencies.
package lir_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int PHASE_BITS  = 23;
    localparam int RATIO_BITS  = 23;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [PHASE_BITS-1:0]         phase_t;
    typedef logic [RATIO_BITS-1:0]         ratio_t;

    localparam phase_t PHASE_ONE   = phase_t'(1) << FRAC_BITS;
    localparam phase_t PHASE_MAX   = '1;
    localparam ratio_t RATIO_RESET = ratio_t'(1) << FRAC_BITS;

endpackage

/* src/linear_interp_resampler_core.sv */
// Stereo linear interpolation sample rate converter, top level.
// Depends on lir_pkg and linear_interp_resampler_core_defines.svh.
//
// Usage:
//   Input words (s_left_in, s_right_in, s_restart) enter on s_valid/s_ready.
//   Each input word yields zero to MAX_RUN output words on m_valid/m_ready;
//   m_run_last marks the last output word caused by an input word.
//   cfg_data (source over target rate, 16 fraction bits) is written on
//   cfg_valid/cfg_ready, which is always ready; write it only while idle.
//   One signed multiplier is shared by both channels under a small
//   sequencer: each output word takes a multiply and an add for left,
//   then for right, then a handshake state; the next output word starts
//   only after the current one is taken. An input word that yields no
//   output leaves s_ready high; otherwise s_ready rises again the cycle
//   after the last output word is taken. First output follows both adds.
//   A stalled receiver holds the output word and the sequencer in place.
//   Reset (aresetn low, synchronous) clears history to zero, sets the phase
//   to one and the rate ratio to 1.0.
`include "linear_interp_resampler_core_defines.svh"

module linear_interp_resampler_core
    import lir_pkg::*;
#(
    parameter int MAX_RUN = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [RATIO_BITS-1:0]         cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_left_in,
    input  logic signed [SAMPLE_BITS-1:0] s_right_in,
    input  logic                          s_restart,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_left_out,
    output logic signed [SAMPLE_BITS-1:0] m_right_out,
    output logic                          m_run_last
);

    localparam int CNT_W  = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_OUT
    } state_t;

    state_t                    state_reg, state_next;
    phase_t                    phase_reg, phase_next;
    ratio_t                    ratio_reg, ratio_next;
    sample_t                   prev_reg [2];
    sample_t                   prev_next [2];
    sample_t                   curr_reg [2];
    sample_t                   curr_next [2];
    logic                      ch_reg, ch_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    sample_t                   left_reg, left_next;
    sample_t                   right_reg, right_next;
    logic                      last_reg, last_next;
    logic                      valid_reg, valid_next;

    logic signed [DIFF_W-1:0]  diff;
    logic signed [FRAC_BITS:0] frac_s;
    logic signed [PROD_W-1:0]  prod_shift;
    logic signed [DIFF_W-1:0]  interp_sum;
    sample_t                   interp_res;
    phase_t                    phase_src;
    phase_t                    phase_dec;
    logic [PHASE_BITS:0]       phase_sum;
    phase_t                    phase_adv;
    logic                      run_end;

    assign cfg_ready   = 1'b1;
    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = valid_reg;
    assign m_left_out  = left_reg;
    assign m_right_out = right_reg;
    assign m_run_last  = last_reg;

    // Shared datapath: difference, multiply, shift and add for the selected channel
    assign diff       = DIFF_W'(curr_reg[ch_reg]) - DIFF_W'(prev_reg[ch_reg]);
    assign frac_s     = $signed({1'b0, phase_reg[FRAC_BITS-1:0]});
    assign prod_shift = prod_reg >>> FRAC_BITS;
    assign interp_sum = DIFF_W'(prev_reg[ch_reg]) + prod_shift[DIFF_W-1:0];
    assign interp_res = interp_sum[SAMPLE_BITS-1:0];

    // Lower the phase by one on each input word (from one on a restart), clamp at zero
    assign phase_src = s_restart ? PHASE_ONE : phase_reg;
    assign phase_dec = (phase_src >= PHASE_ONE) ? (phase_src - PHASE_ONE) : '0;

    // Advance the phase by the ratio, saturate at full scale
    assign phase_sum = {1'b0, phase_reg} + {1'b0, ratio_reg};
    assign phase_adv = phase_sum[PHASE_BITS] ? PHASE_MAX : phase_sum[PHASE_BITS-1:0];
    assign run_end   = (phase_adv >= PHASE_ONE) || (cnt_reg == CNT_W'(MAX_RUN - 1));

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        ratio_next = ratio_reg;
        prev_next  = prev_reg;
        curr_next  = curr_reg;
        ch_next    = ch_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        left_next  = left_reg;
        right_next = right_reg;
        last_next  = last_reg;
        valid_next = valid_reg;

        if (cfg_valid && cfg_ready) begin
            ratio_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    prev_next[0] = s_restart ? '0 : curr_reg[0];
                    prev_next[1] = s_restart ? '0 : curr_reg[1];
                    curr_next[0] = s_left_in;
                    curr_next[1] = s_right_in;
                    phase_next   = phase_dec;
                    ch_next      = 1'b0;
                    cnt_next     = '0;
                    state_next   = (phase_dec < PHASE_ONE) ? ST_MUL : ST_IDLE;
                end
            end
            ST_MUL: begin
                prod_next  = diff * frac_s;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                if (!ch_reg) begin
                    left_next  = interp_res;
                    ch_next    = 1'b1;
                    state_next = ST_MUL;
                end else begin
                    right_next = interp_res;
                    ch_next    = 1'b0;
                    last_next  = run_end;
                    valid_next = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    valid_next = 1'b0;
                    phase_next = phase_adv;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = last_reg ? ST_IDLE : ST_MUL;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, history and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PHASE_ONE;
            ratio_reg <= RATIO_RESET;
            prev_reg  <= '{default: '0};
            curr_reg  <= '{default: '0};
            ch_reg    <= 1'b0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            ratio_reg <= ratio_next;
            prev_reg  <= prev_next;
            curr_reg  <= curr_next;
            ch_reg    <= ch_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
        prod_reg  <= prod_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        last_reg  <= last_next;
    end

    `LIR_ASSERT(a_ready_excl_valid, aclk, aresetn, !(s_ready && m_valid),
        "input ready while an output word is pending")
    `LIR_ASSERT(a_phase_frac, aclk, aresetn, m_valid |-> (phase_reg < PHASE_ONE),
        "output word presented with phase at or above one")
    `LIR_ASSERT(a_last_to_idle, aclk, aresetn, (m_valid && m_ready && m_run_last) |=> s_ready,
        "sequencer did not return to idle after the last word")
    `LIR_ASSERT(a_run_continues, aclk, aresetn,
        (m_valid && m_ready && !m_run_last) |=> (!s_ready && !m_valid),
        "run ended early after a non-last word")

endmodule
